// File: rtl/oled_framebuffer_i2c_refresh_macros.svh
`ifndef OLED_FRAMEBUFFER_I2C_REFRESH_MACROS_SVH
`define OLED_FRAMEBUFFER_I2C_REFRESH_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ofr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ofr_pkg;

    localparam int COLUMNS     = 128;
    localparam int PAGES       = 8;
    localparam int ROWS        = 8 * PAGES;
    localparam int STORE_BYTES = COLUMNS * PAGES;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int BCNT_W      = ($clog2(COLUMNS) < 2) ? 2 : $clog2(COLUMNS);
    localparam int PAGE_W      = (PAGES > 1) ? $clog2(PAGES) : 1;

    localparam logic [1:0] REG_DEV_ADDR   = 2'd0;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h78;
    localparam logic [7:0] CTRL_CMD       = 8'h00;
    localparam logic [7:0] CTRL_DATA      = 8'h40;
    localparam logic [7:0] PAGE_CMD_BASE  = 8'hB0;
    localparam logic [7:0] COL_LOW_CMD    = 8'h00;
    localparam logic [7:0] COL_HIGH_CMD   = 8'h10;

    typedef enum logic [1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_START = 2'd2,
        CMD_TICK  = 2'd3
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic start;
        logic tick;
    } t_step;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic scl;
        logic sda;
        logic busy;
        logic done;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/ofr_refresh.sv
`timescale 1ns / 1ps
`default_nettype none

`include "oled_framebuffer_i2c_refresh_macros.svh"

module ofr_refresh import ofr_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_step      i_step,
    input  wire logic [7:0] i_dev_addr,
    input  wire logic [7:0] i_rd_data,
    output t_rd_req         o_rd_req,
    output t_res            o_res
);

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_ADDR  = 3'd1,
        K_ACKA  = 3'd2,
        K_CTRL  = 3'd3,
        K_ACKC  = 3'd4,
        K_PAY   = 3'd5,
        K_ACKP  = 3'd6,
        K_STOP  = 3'd7
    } t_kind;

    logic              r_busy,  n_busy;
    logic              r_is_data, n_is_data;
    t_kind             r_kind,  n_kind;
    logic [PAGE_W-1:0] r_page,  n_page;
    logic [BCNT_W-1:0] r_bcnt,  n_bcnt;
    logic [4:0]        r_bit,   n_bit;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;
    logic              r_pend,  n_pend;

    logic       shift_eff;
    logic [7:0] shift_cur;
    logic       ent;
    t_kind      ent_kind;
    logic       done;

    // A data byte read from the store lands in the cycle after the read; until it
    // is taken into the shift register it is used straight from the memory.
    assign shift_cur = r_pend ? i_rd_data : r_shift;
    assign shift_eff = shift_cur[7];

    always_comb begin
        n_busy    = r_busy;
        n_is_data = r_is_data;
        n_kind    = r_kind;
        n_page    = r_page;
        n_bcnt    = r_bcnt;
        n_bit     = r_bit;
        n_shift   = shift_cur;
        n_scl     = r_scl;
        n_sda     = r_sda;
        n_pend    = 1'b0;
        ent       = 1'b0;
        ent_kind  = K_START;
        done      = 1'b0;
        o_rd_req  = '0;

        if (i_step.adv && i_step.start && !r_busy) begin
            n_busy    = 1'b1;
            n_is_data = 1'b0;
            n_page    = '0;
            n_bcnt    = '0;
            ent       = 1'b1;
            ent_kind  = K_START;
        end else if (i_step.adv && i_step.tick && r_busy) begin
            unique case (r_kind)
                K_START: begin
                    case (r_bit)
                        5'd0:    n_sda = 1'b1;
                        5'd1:    n_scl = 1'b1;
                        5'd2:    n_sda = 1'b0;
                        default: n_scl = 1'b0;
                    endcase
                    if (r_bit >= 5'd3) begin
                        ent      = 1'b1;
                        ent_kind = K_ADDR;
                    end else begin
                        n_bit = r_bit + 5'd1;
                    end
                end
                K_ADDR, K_CTRL, K_PAY: begin
                    case (r_bit[1:0])
                        2'd0:    n_scl = 1'b0;
                        2'd1:    n_sda = shift_eff;
                        2'd2:    n_scl = 1'b1;
                        default: begin
                            n_scl   = 1'b0;
                            n_shift = {shift_cur[6:0], 1'b0};
                        end
                    endcase
                    if (r_bit == 5'd31) begin
                        ent      = 1'b1;
                        ent_kind = t_kind'(r_kind + 3'd1);
                    end else begin
                        n_bit = r_bit + 5'd1;
                    end
                end
                K_ACKA, K_ACKC, K_ACKP: begin
                    if (r_bit == 5'd0) begin
                        n_scl = 1'b1;
                        n_bit = 5'd1;
                    end else begin
                        n_scl = 1'b0;
                        ent   = 1'b1;
                        if (r_kind == K_ACKA) begin
                            ent_kind = K_CTRL;
                        end else if (r_kind == K_ACKC) begin
                            ent_kind = K_PAY;
                        end else if (r_is_data && r_bcnt != BCNT_W'(COLUMNS - 1)) begin
                            n_bcnt   = r_bcnt + BCNT_W'(1);
                            ent_kind = K_PAY;
                        end else begin
                            ent_kind = K_STOP;
                        end
                    end
                end
                K_STOP: begin
                    if (r_bit == 5'd0) begin
                        n_scl = 1'b1;
                        n_bit = 5'd1;
                    end else if (r_bit == 5'd1) begin
                        n_sda = 1'b0;
                        n_bit = 5'd2;
                    end else begin
                        n_sda = 1'b1;
                        if (!r_is_data) begin
                            ent      = 1'b1;
                            ent_kind = K_START;
                            if (r_bcnt < BCNT_W'(2)) begin
                                n_bcnt = r_bcnt + BCNT_W'(1);
                            end else begin
                                n_bcnt    = '0;
                                n_is_data = 1'b1;
                            end
                        end else if (r_page >= PAGE_W'(PAGES - 1)) begin
                            n_busy    = 1'b0;
                            n_is_data = 1'b0;
                            n_kind    = K_START;
                            n_bit     = '0;
                            n_bcnt    = '0;
                            n_page    = '0;
                            done      = 1'b1;
                        end else begin
                            ent       = 1'b1;
                            ent_kind  = K_START;
                            n_page    = r_page + PAGE_W'(1);
                            n_bcnt    = '0;
                            n_is_data = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end

        if (ent) begin
            n_kind = ent_kind;
            n_bit  = '0;
            case (ent_kind)
                K_ADDR: n_shift = i_dev_addr;
                K_CTRL: n_shift = n_is_data ? CTRL_DATA : CTRL_CMD;
                K_PAY: begin
                    if (n_is_data) begin
                        o_rd_req.en   = 1'b1;
                        o_rd_req.addr = ADDR_W'(int'(n_page) * COLUMNS + int'(n_bcnt));
                        n_pend        = 1'b1;
                    end else if (n_bcnt == BCNT_W'(0)) begin
                        n_shift = PAGE_CMD_BASE + 8'(n_page);
                    end else if (n_bcnt == BCNT_W'(1)) begin
                        n_shift = COL_LOW_CMD;
                    end else begin
                        n_shift = COL_HIGH_CMD;
                    end
                end
                default: ;
            endcase
        end

        o_res.scl  = n_scl;
        o_res.sda  = n_sda;
        o_res.busy = n_busy;
        o_res.done = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_is_data <= 1'b0;
            r_kind    <= K_START;
            r_page    <= '0;
            r_bcnt    <= '0;
            r_bit     <= '0;
            r_shift   <= '0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_pend    <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_is_data <= n_is_data;
            r_kind    <= n_kind;
            r_page    <= n_page;
            r_bcnt    <= n_bcnt;
            r_bit     <= n_bit;
            r_shift   <= n_shift;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_pend    <= n_pend;
        end
    end

    // Every transaction ends with a stop, so an idle bus sits with both lines high.
    `OFR_ASSERT_NOW(a_idle_bus_high, i_clk, i_rst_n, !r_busy, r_scl && r_sda, "idle bus not released")
    `OFR_ASSERT_NOW(a_pend_in_payload, i_clk, i_rst_n, r_pend,
        r_busy && r_is_data && r_kind == K_PAY && r_bit == 5'd0, "store byte load out of place")
    `OFR_ASSERT_NOW(a_done_at_last_stop, i_clk, i_rst_n, done,
        r_is_data && r_kind == K_STOP && r_page == PAGE_W'(PAGES - 1), "refresh ended early")

endmodule

`default_nettype wire

// File: rtl/oled_framebuffer_i2c_refresh.sv
// Channel  | Handshake               | Word
// ---------+-------------------------+-----------------------------------------------
// in       | i_in_valid / o_in_stall | i_cmd, i_pixel_x, i_pixel_y
// out      | o_out_valid / i_out_stall | o_scl_level, o_sda_level, o_busy_res, o_refresh_done
// config   | psel, penable, pwrite   | paddr, pwdata, prdata (device write address)
//
// One word is accepted per cycle while o_in_stall is low. The word and its store read are
// held in the pipeline stage, then read-modify-write and bus step feed the output register.
// After reset the frame store is cleared one byte a cycle; o_in_stall stays high until all
// STORE_BYTES bytes (1024 with the default geometry) are cleared. Config writes are taken throughout.
// A stall on the output holds the word in the pipeline stage and stalls the input.
`timescale 1ns / 1ps
`default_nettype none

`include "oled_framebuffer_i2c_refresh_macros.svh"

module oled_framebuffer_i2c_refresh import ofr_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [6:0]  i_pixel_x,
    input  wire logic [5:0]  i_pixel_y,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_scl_level,
    output logic             o_sda_level,
    output logic             o_busy_res,
    output logic             o_refresh_done,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]        r_mem [STORE_BYTES];
    logic [7:0]        r_rda;
    logic [7:0]        r_rdb;

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [7:0]        r_dev_addr;

    logic              r_s1_valid;
    t_cmd              r_s1_cmd;
    logic              r_s1_in_range;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [7:0]        r_s1_mask;
    logic              r_s1_fwd_hit;
    logic [7:0]        r_s1_fwd_data;

    logic              r_out_valid;
    t_res              r_out;

    t_cmd              cmd0;
    logic              in_range0;
    logic [ADDR_W-1:0] addr0;
    logic [7:0]        mask0;
    logic              accept;
    logic              out_free;
    logic              s1_adv;
    logic              rda_en;
    logic              pix_we;
    logic [7:0]        pix_base;
    logic [7:0]        pix_new;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;
    logic              cfg_wr;
    t_step             step;
    t_rd_req           rd_req;
    t_res              res;

    assign cmd0      = t_cmd'(i_cmd);
    assign in_range0 = (int'(i_pixel_x) < COLUMNS) && (int'(i_pixel_y) < ROWS);
    assign addr0     = ADDR_W'((int'(i_pixel_y) >> 3) * COLUMNS + int'(i_pixel_x));
    assign mask0     = 8'd1 << i_pixel_y[2:0];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_clearing || (r_s1_valid && !out_free);
    assign accept     = i_in_valid && !o_in_stall;
    assign rda_en     = accept && (cmd0 == CMD_SET || cmd0 == CMD_CLEAR) && in_range0;

    // The previous word's write lands on the same edge as this word's read, so a
    // matching address takes the written byte instead of the stale read.
    assign pix_base = r_s1_fwd_hit ? r_s1_fwd_data : r_rda;
    assign pix_new  = (r_s1_cmd == CMD_SET) ? (pix_base | r_s1_mask)
                                            : (pix_base & ~r_s1_mask);
    assign pix_we   = s1_adv && r_s1_in_range
                    && (r_s1_cmd == CMD_SET || r_s1_cmd == CMD_CLEAR);

    assign mem_we = r_clearing || pix_we;
    assign mem_wa = r_clearing ? r_clr_addr : r_s1_addr;
    assign mem_wd = r_clearing ? 8'd0 : pix_new;

    assign step.adv   = s1_adv;
    assign step.start = (r_s1_cmd == CMD_START);
    assign step.tick  = (r_s1_cmd == CMD_TICK);

    ofr_refresh u_refresh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_dev_addr (r_dev_addr),
        .i_rd_data  (r_rdb),
        .o_rd_req   (rd_req),
        .o_res      (res)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rda_en) begin
            r_rda <= r_mem[addr0];
        end
        if (rd_req.en) begin
            r_rdb <= r_mem[rd_req.addr];
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_DEV_ADDR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_dev_addr  <= DEV_ADDR_RESET;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (cfg_wr) begin
                r_dev_addr <= pwdata[7:0];
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd      <= cmd0;
            r_s1_in_range <= in_range0;
            r_s1_addr     <= addr0;
            r_s1_mask     <= mask0;
            r_s1_fwd_hit  <= pix_we && (r_s1_addr == addr0);
            r_s1_fwd_data <= pix_new;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_level    = r_out.scl;
    assign o_sda_level    = r_out.sda;
    assign o_busy_res     = r_out.busy;
    assign o_refresh_done = r_out.done;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_DEV_ADDR) ? {24'd0, r_dev_addr} : 32'd0;

    `OFR_ASSERT_NOW(a_clear_pipe_empty, i_clk, i_rst_n, r_clearing,
        !r_s1_valid && !r_out_valid, "word in flight during store clear")
    `OFR_ASSERT_NEXT(a_stage_holds, i_clk, i_rst_n, r_s1_valid && !out_free,
        r_s1_valid && $stable(r_s1_addr) && $stable(r_s1_cmd), "stalled stage lost its word")
    `OFR_ASSERT_NEXT(a_fwd_capture, i_clk, i_rst_n, accept && pix_we && r_s1_addr == addr0,
        r_s1_fwd_hit, "same-byte write not forwarded")

endmodule

`default_nettype wire
